// ===== rtl/core/biquad_iir_filter_macros.svh =====
// ----------------------------------------------------------------------------
// Biquad IIR filter assertion macros
// Shared concurrent assertion forms for the biquad RTL.
// ----------------------------------------------------------------------------
`ifndef BIQUAD_IIR_FILTER_MACROS_SVH
`define BIQUAD_IIR_FILTER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define BIQ_ASSERT_IMP(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("biquad assertion failed");

// Next-cycle implication, disabled during reset.
`define BIQ_ASSERT_NXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("biquad assertion failed");

`endif

// ===== rtl/core/biq_pkg.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR filter package
// Widths, register indexes, reset values and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package biq_pkg;

   localparam int SMP_W        = 24;
   localparam int COEF_W       = 26;
   localparam int FRAC_SHIFT   = 22;
   localparam int PROD_W       = SMP_W + COEF_W;
   localparam int ACC_W        = PROD_W + 3;
   localparam int CSR_IDX_W    = 3;
   localparam int CHANNELS_DEF = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_B0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_B1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_B2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_A1 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_A2 = 3'd4;

   localparam logic signed [COEF_W-1:0] B0_RST = 26'sd4194304;
   localparam logic signed [SMP_W-1:0]  SMP_MAX = 24'sh7FFFFF;
   localparam logic signed [SMP_W-1:0]  SMP_MIN = 24'sh800000;
   localparam logic signed [ACC_W-1:0]  RND_BIAS = ACC_W'(1) <<< (FRAC_SHIFT - 1);

   typedef struct packed {
      logic signed [COEF_W-1:0] b0;
      logic signed [COEF_W-1:0] b1;
      logic signed [COEF_W-1:0] b2;
      logic signed [COEF_W-1:0] a1;
      logic signed [COEF_W-1:0] a2;
   } coef_type;

   // One history entry: last two inputs and last two outputs of a channel.
   typedef struct packed {
      logic signed [SMP_W-1:0] x1;
      logic signed [SMP_W-1:0] x2;
      logic signed [SMP_W-1:0] y1;
      logic signed [SMP_W-1:0] y2;
   } hist_type;

   typedef struct packed {
      logic     en;
      logic     ch;
      hist_type data;
   } wb_type;

   typedef struct packed {
      logic                    vld;
      logic                    ch;
      logic signed [SMP_W-1:0] y;
      logic                    clip;
   } res_type;

endpackage

`default_nettype wire

// ===== rtl/core/biq_hist_ram.sv =====
// ----------------------------------------------------------------------------
// Biquad history memory
// One-read one-write synchronous memory of history entries with registered
// read data; entries never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module biq_hist_ram #(
   parameter int DEPTH  = biq_pkg::CHANNELS_DEF,
   parameter int ADDR_W = 1
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output biq_pkg::hist_type      rd_data,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  biq_pkg::hist_type      wr_data
);

   biq_pkg::hist_type mem_ff [DEPTH];
   logic              ent_vld_ff [DEPTH];
   biq_pkg::hist_type rd_word_ff;
   logic              rd_hit_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_word_ff <= mem_ff[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < DEPTH; i++) begin
            ent_vld_ff[i] <= 1'b0;
         end
         rd_hit_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            ent_vld_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_hit_ff <= ent_vld_ff[rd_addr];
         end
      end
   end

   assign rd_data = rd_hit_ff ? rd_word_ff : '0;

endmodule

`default_nettype wire

// ===== rtl/core/biq_datapath.sv =====
// ----------------------------------------------------------------------------
// Biquad datapath
// Two stages: feedforward products with input-history forwarding, then
// feedback products, rounding, saturation and history write-back.
// ----------------------------------------------------------------------------
`default_nettype none
`include "biquad_iir_filter_macros.svh"

module biq_datapath (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              adv,
   input  wire logic                              in_vld,
   input  wire logic                              in_ok,
   input  wire logic                              in_ch,
   input  wire logic signed [biq_pkg::SMP_W-1:0]  in_x,
   input  biq_pkg::coef_type                      coef,
   input  biq_pkg::hist_type                      rd_data,
   output biq_pkg::wb_type                        wr,
   output biq_pkg::res_type                       res
);

   localparam int SMP_W  = biq_pkg::SMP_W;
   localparam int PROD_W = biq_pkg::PROD_W;
   localparam int ACC_W  = biq_pkg::ACC_W;
   localparam int FRAC   = biq_pkg::FRAC_SHIFT;
   localparam int TOP_LO = FRAC + SMP_W - 1;

   // stage 1
   logic                     s1_vld_ff;
   logic                     s1_ok_ff;
   logic                     s1_ch_ff;
   logic signed [SMP_W-1:0]  s1_x_ff;

   // stage 2
   logic                     s2_vld_ff;
   logic                     s2_ok_ff;
   logic                     s2_ch_ff;
   logic                     s2_fwd_ff;
   logic signed [SMP_W-1:0]  s2_x_ff;
   logic signed [SMP_W-1:0]  s2_x1_ff;
   logic signed [SMP_W-1:0]  s2_y1_ff;
   logic signed [SMP_W-1:0]  s2_y2_ff;
   logic signed [ACC_W-1:0]  s2_ff_ff;

   biq_pkg::wb_type          wb_ff;

   logic                     s1_hit2;
   logic                     s1_hitw;
   biq_pkg::hist_type        s1_base;
   logic signed [SMP_W-1:0]  s1_x1;
   logic signed [SMP_W-1:0]  s1_x2;
   logic signed [PROD_W-1:0] p0;
   logic signed [PROD_W-1:0] p1;
   logic signed [PROD_W-1:0] p2;
   logic signed [ACC_W-1:0]  s1_ff;

   logic signed [SMP_W-1:0]  y1;
   logic signed [SMP_W-1:0]  y2;
   logic signed [PROD_W-1:0] fb1;
   logic signed [PROD_W-1:0] fb2;
   logic signed [ACC_W-1:0]  acc;
   logic [ACC_W-1:TOP_LO]    acc_top;
   logic                     clip;
   logic signed [SMP_W-1:0]  y_sat;

   // Item directly ahead on the same channel supplies the input history;
   // the last write covers the entry the memory read just missed.
   always_comb begin
      s1_hit2 = s2_vld_ff && s2_ok_ff && s1_ok_ff && (s2_ch_ff == s1_ch_ff);
      s1_hitw = wb_ff.en && s1_ok_ff && (wb_ff.ch == s1_ch_ff);
      if (!s1_ok_ff) begin
         s1_base = '0;
      end else if (s1_hitw) begin
         s1_base = wb_ff.data;
      end else begin
         s1_base = rd_data;
      end
      s1_x1 = s1_hit2 ? s2_x_ff  : s1_base.x1;
      s1_x2 = s1_hit2 ? s2_x1_ff : s1_base.x2;
   end

   assign p0    = coef.b0 * s1_x_ff;
   assign p1    = coef.b1 * s1_x1;
   assign p2    = coef.b2 * s1_x2;
   assign s1_ff = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2);

   // Output history of the item just written comes from the last write.
   assign y1  = s2_fwd_ff ? wb_ff.data.y1 : s2_y1_ff;
   assign y2  = s2_fwd_ff ? wb_ff.data.y2 : s2_y2_ff;
   assign fb1 = coef.a1 * y1;
   assign fb2 = coef.a2 * y2;
   assign acc = s2_ff_ff - ACC_W'(fb1) - ACC_W'(fb2) + biq_pkg::RND_BIAS;

   always_comb begin
      acc_top = acc[ACC_W-1:TOP_LO];
      clip    = !((acc_top == '0) || (acc_top == '1));
      if (!clip) begin
         y_sat = acc[TOP_LO:FRAC];
      end else if (acc[ACC_W-1]) begin
         y_sat = biq_pkg::SMP_MIN;
      end else begin
         y_sat = biq_pkg::SMP_MAX;
      end
   end

   always_comb begin
      wr.en      = adv && s2_vld_ff && s2_ok_ff;
      wr.ch      = s2_ch_ff;
      wr.data.x1 = s2_x_ff;
      wr.data.x2 = s2_x1_ff;
      wr.data.y1 = y_sat;
      wr.data.y2 = y1;
      res.vld    = s2_vld_ff;
      res.ch     = s2_ch_ff;
      res.y      = y_sat;
      res.clip   = clip;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff <= 1'b0;
         s2_vld_ff <= 1'b0;
         wb_ff     <= '0;
      end else if (adv) begin
         s1_vld_ff <= in_vld;
         s2_vld_ff <= s1_vld_ff;
         wb_ff     <= wr;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ok_ff  <= in_ok;
         s1_ch_ff  <= in_ch;
         s1_x_ff   <= in_x;
         s2_ok_ff  <= s1_ok_ff;
         s2_ch_ff  <= s1_ch_ff;
         s2_fwd_ff <= s1_vld_ff && s1_hit2;
         s2_x_ff   <= s1_x_ff;
         s2_x1_ff  <= s1_x1;
         s2_y1_ff  <= s1_base.y1;
         s2_y2_ff  <= s1_base.y2;
         s2_ff_ff  <= s1_ff;
      end
   end

   `BIQ_ASSERT_IMP(a_fwd_src, clock, reset, s2_vld_ff && s2_fwd_ff, wb_ff.en && wb_ff.ch == s2_ch_ff)
   `BIQ_ASSERT_IMP(a_clip_rail, clock, reset, s2_vld_ff && clip, y_sat == biq_pkg::SMP_MAX || y_sat == biq_pkg::SMP_MIN)

endmodule

`default_nettype wire

// ===== rtl/core/biquad_iir_filter.sv =====
// ----------------------------------------------------------------------------
// Biquad IIR filter, direct form I
// Per-channel second-order section with history kept in a synchronous memory.
// ----------------------------------------------------------------------------
//  Channel | Ports                                          | Handshake
//  --------+------------------------------------------------+-----------------
//  req     | req_channel, req_sample_in                     | req_valid/ready
//  rsp     | rsp_channel_out, rsp_sample_out, rsp_clipped   | rsp_valid/ready
//  csr     | csr_index, csr_wdata                           | csr_wen
//
//  One item per cycle while the pipe advances, also back to back on one
//  channel; each result passes a memory read with the item, then feedforward,
//  then feedback into the output register.
//  The feedback path (two multiplies, add, round, saturate) sets the clock.
//  Reset clears history valid bits at once: no clearing pass.
//  A stalled result stalls the pipe only when a finished item waits behind it.
// ----------------------------------------------------------------------------
`default_nettype none
`include "biquad_iir_filter_macros.svh"

module biquad_iir_filter #(
   parameter int CHANNELS = biq_pkg::CHANNELS_DEF
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output      logic                                req_ready,
   input  wire logic                                req_channel,
   input  wire logic signed [biq_pkg::SMP_W-1:0]    req_sample_in,
   output      logic                                rsp_valid,
   input  wire logic                                rsp_ready,
   output      logic                                rsp_channel_out,
   output      logic signed [biq_pkg::SMP_W-1:0]    rsp_sample_out,
   output      logic                                rsp_clipped,
   input  wire logic                                csr_wen,
   input  wire logic [biq_pkg::CSR_IDX_W-1:0]       csr_index,
   input  wire logic [biq_pkg::COEF_W-1:0]          csr_wdata
);

   localparam int ADDR_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

   biq_pkg::coef_type               coef_ff;
   biq_pkg::coef_type               coef_in;
   biq_pkg::wb_type                 wr;
   biq_pkg::res_type                res;
   biq_pkg::hist_type               rd_data;
   logic                            adv;
   logic                            chan_ok;
   logic [ADDR_W-1:0]               rd_addr;
   logic                            rsp_valid_ff;
   logic                            rsp_channel_ff;
   logic signed [biq_pkg::SMP_W-1:0] rsp_sample_ff;
   logic                            rsp_clipped_ff;

   // Advance while the output register is free, drains, or nothing waits for it.
   assign adv       = !res.vld || !rsp_valid_ff || rsp_ready;
   assign req_ready = adv;
   assign chan_ok   = (CHANNELS > 1) || (req_channel == 1'b0);
   assign rd_addr   = chan_ok ? ADDR_W'(req_channel) : '0;

   always_comb begin
      coef_in = coef_ff;
      if (csr_wen) begin
         case (csr_index)
            biq_pkg::CSR_B0: coef_in.b0 = csr_wdata;
            biq_pkg::CSR_B1: coef_in.b1 = csr_wdata;
            biq_pkg::CSR_B2: coef_in.b2 = csr_wdata;
            biq_pkg::CSR_A1: coef_in.a1 = csr_wdata;
            biq_pkg::CSR_A2: coef_in.a2 = csr_wdata;
            default:         coef_in = coef_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         coef_ff <= '{b0: biq_pkg::B0_RST, b1: '0, b2: '0, a1: '0, a2: '0};
      end else begin
         coef_ff <= coef_in;
      end
   end

   biq_hist_ram #(
      .DEPTH  (CHANNELS),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_en   (adv),
      .rd_addr (rd_addr),
      .rd_data (rd_data),
      .wr_en   (wr.en),
      .wr_addr (ADDR_W'(wr.ch)),
      .wr_data (wr.data)
   );

   biq_datapath u_dp (
      .clock   (clock),
      .reset   (reset),
      .adv     (adv),
      .in_vld  (req_valid),
      .in_ok   (chan_ok),
      .in_ch   (req_channel),
      .in_x    (req_sample_in),
      .coef    (coef_ff),
      .rd_data (rd_data),
      .wr      (wr),
      .res     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv && res.vld) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (adv && res.vld) begin
         rsp_channel_ff <= res.ch;
         rsp_sample_ff  <= res.y;
         rsp_clipped_ff <= res.clip;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_channel_out = rsp_channel_ff;
   assign rsp_sample_out  = rsp_sample_ff;
   assign rsp_clipped     = rsp_clipped_ff;

   `BIQ_ASSERT_IMP(a_hold_full, clock, reset, res.vld && rsp_valid_ff && !rsp_ready, !req_ready)
   `BIQ_ASSERT_NXT(a_drain, clock, reset, rsp_valid_ff && rsp_ready && !res.vld, !rsp_valid_ff)

endmodule

`default_nettype wire
